// ----- rtl/core/kms_pkg.sv -----
package kms_pkg;

  // fixed point default and field widths
  localparam int FRAC_BITS_DEF = 16;
  localparam int MOTION_W      = 32;
  localparam int Q_W           = 17;
  localparam int R_W           = 25;
  localparam int LIM_W         = 31;
  localparam int CFG_DATA_W    = 31;
  localparam int CFG_IDX_W     = 2;
  localparam int COV_W         = 32;
  localparam int P1_W          = COV_W + 1;
  localparam int DEN_W         = P1_W + 1;
  localparam int CORR_W        = MOTION_W + 2;

  // trajectory lanes: x, y, angle
  localparam int LANES       = 3;
  localparam int LANE_TX     = 0;
  localparam int LANE_TY     = 1;
  localparam int LANE_ANGLE  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATION_LIMIT = 2'd2;

  typedef struct packed {
    logic                       motion_found;
    logic signed [MOTION_W-1:0] trans_x;
    logic signed [MOTION_W-1:0] trans_y;
    logic signed [MOTION_W-1:0] rot_angle;
    logic signed [MOTION_W-1:0] scale_x;
    logic signed [MOTION_W-1:0] scale_y;
  } kms_in_t;

  typedef struct packed {
    logic                       bypass;
    logic signed [MOTION_W-1:0] corr_trans_x;
    logic signed [MOTION_W-1:0] corr_trans_y;
    logic signed [MOTION_W-1:0] corr_angle;
    logic signed [MOTION_W-1:0] out_scale_x;
    logic signed [MOTION_W-1:0] out_scale_y;
  } kms_out_t;

  typedef struct packed {
    logic sum_en;
    logic mul_en;
    logic est_en;
  } kms_lane_ctrl_t;

  typedef struct packed {
    logic start;
    logic mul_en;
    logic upd_en;
  } kms_cov_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_CORR
  } kms_state_t;

  // saturate a wide signed value to the motion width
  function automatic logic signed [MOTION_W-1:0] sat_motion(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (MOTION_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return MOTION_W'(hi);
    end else if (v < lo) begin
      return MOTION_W'(lo);
    end
    return MOTION_W'(v);
  endfunction

endpackage

// ----- rtl/core/kms_cov.sv -----
module kms_cov #(
  parameter int FRAC_BITS = kms_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kms_pkg::kms_cov_ctrl_t     ctrl,
  input  logic [kms_pkg::Q_W-1:0]    process_noise,
  input  logic [kms_pkg::R_W-1:0]    measurement_noise,
  output logic [FRAC_BITS:0]         gain,
  output logic                       div_done
);
  import kms_pkg::*;

  localparam int GAIN_W = FRAC_BITS + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int PROD_W = GAIN_W + P1_W;
  localparam logic [GAIN_W-1:0] ONE  = GAIN_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]  LAST = CNT_W'(FRAC_BITS);
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] COV_MAX = PROD_W'({COV_W{1'b1}});
  localparam logic [COV_W-1:0]  COV_RESET = COV_W'(1) << FRAC_BITS;

  logic [COV_W-1:0]  error_cov;
  logic [P1_W-1:0]   p1;
  logic [P1_W-1:0]   p1_next;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  den_next;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sub;
  logic              rem_ge;
  logic [GAIN_W-1:0] quot;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] pn;

  // predicted covariance and gain denominator
  assign p1_next  = P1_W'(error_cov) + P1_W'(process_noise);
  assign den_next = DEN_W'(p1_next) + DEN_W'(measurement_noise);

  // one restoring step per cycle
  assign rem_ge  = (rem >= REM_W'(den));
  assign rem_sub = rem_ge ? (rem - REM_W'(den)) : rem;

  assign div_done = busy && (cnt == LAST);

  // a zero denominator leaves an all ones quotient, which caps to unity
  assign gain = (quot > ONE) ? ONE : quot;

  assign pn = (prod + HALF) >> FRAC_BITS;

  // divider control and covariance
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      error_cov <= COV_RESET;
    end else begin
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
      if (ctrl.upd_en) begin
        error_cov <= (pn > COV_MAX) ? {COV_W{1'b1}} : COV_W'(pn);
      end
    end
  end

  // divider datapath and covariance product
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      p1  <= p1_next;
      den <= den_next;
      rem <= REM_W'(p1_next);
    end else if (busy) begin
      quot <= {quot[GAIN_W-2:0], rem_ge};
      rem  <= {rem_sub[REM_W-2:0], 1'b0};
    end
    if (ctrl.mul_en) begin
      prod <= PROD_W'(ONE - gain) * PROD_W'(p1);
    end
  end

endmodule

// ----- rtl/core/kms_lane.sv -----
module kms_lane #(
  parameter int FRAC_BITS = kms_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  kms_pkg::kms_lane_ctrl_t             ctrl,
  input  logic                                clamp_en,
  input  logic signed [kms_pkg::MOTION_W-1:0] motion,
  input  logic [FRAC_BITS:0]                  gain,
  input  logic [kms_pkg::LIM_W-1:0]           limit,
  output logic signed [kms_pkg::MOTION_W-1:0] corr
);
  import kms_pkg::*;

  localparam int GAIN_SW = FRAC_BITS + 2;
  localparam int DIFF_W  = MOTION_W + 1;
  localparam int PROD_W  = DIFF_W + GAIN_SW;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic signed [MOTION_W-1:0] sum;
  logic signed [MOTION_W-1:0] est;
  logic signed [MOTION_W-1:0] sum_next;
  logic signed [MOTION_W-1:0] est_next;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [GAIN_SW-1:0]  gain_s;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   step;
  logic signed [CORR_W-1:0]   corr_wide;
  logic signed [CORR_W-1:0]   lim_s;

  // running sum and innovation
  assign sum_next = sat_motion(64'(sum) + 64'(motion));
  assign diff     = DIFF_W'(sum) - DIFF_W'(est);
  assign gain_s   = signed'({1'b0, gain});

  // rounded estimate step, ties toward plus infinity
  assign step     = (prod + HALF) >>> FRAC_BITS;
  assign est_next = sat_motion(64'(est) + 64'(step));

  // correction and clamp
  assign corr_wide = CORR_W'(motion) + CORR_W'(est) - CORR_W'(sum);
  assign lim_s     = signed'(CORR_W'(limit));

  always_comb begin
    if (clamp_en) begin
      if (corr_wide > lim_s) begin
        corr = MOTION_W'(lim_s);
      end else if (corr_wide < -lim_s) begin
        corr = MOTION_W'(-lim_s);
      end else begin
        corr = MOTION_W'(corr_wide);
      end
    end else begin
      corr = sat_motion(64'(corr_wide));
    end
  end

  // trajectory state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      est <= '0;
    end else begin
      if (ctrl.sum_en) begin
        sum <= sum_next;
      end
      if (ctrl.est_en) begin
        est <= est_next;
      end
    end
  end

  // gain product
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(diff) * PROD_W'(gain_s);
    end
  end

endmodule

// ----- rtl/core/kalman_motion_smoother_unit.sv -----
// Motion smoother: takes one word per video frame with the estimated frame
// motion and returns one word with the smoothed motion for the warp.
// Input channel in_valid/in_ready/in_word, output channel
// out_valid/out_ready/out_word; words are taken when valid and ready are high.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data;
// the user must write them only while no word is in flight, as the block does
// not enforce this; unknown indexes are ignored.
// A word with no motion passes through the correction state into the output
// register as a bypass word, and the block is then ready again. The first
// word with motion only updates the trajectory sums (sum state, then
// correction state). Later words run the Kalman update through the sum,
// divide, multiply, update and correction states; the gain comes from a
// restoring divider giving one quotient bit a cycle.
// Three lanes (x, y, angle) share the gain and run side by side.
// Reset clears sums and estimates, sets the covariance to 1.0 and loads the
// default noise and limit settings. A result held by a stalled receiver sits
// in the output register; the next word may be taken meanwhile and waits at
// its final step until that register is free.
module kalman_motion_smoother_unit #(
  parameter int FRAC_BITS = kms_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  kms_pkg::kms_in_t                     in_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output kms_pkg::kms_out_t                    out_word,
  input  logic                                 cfg_wr_en,
  input  logic [kms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import kms_pkg::*;

  localparam logic [Q_W-1:0]   Q_RESET   = Q_W'((4 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [R_W-1:0]   R_RESET   = R_W'(1 << (FRAC_BITS - 1));
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(50 * (1 << FRAC_BITS));

  kms_state_t     state;
  kms_state_t     state_next;
  kms_in_t        in_r;
  kms_out_t       out_next;
  kms_lane_ctrl_t lane_ctrl;
  kms_cov_ctrl_t  cov_ctrl;
  logic           first_seen;
  logic           first_set;
  logic           out_load;
  logic           div_done;
  logic [FRAC_BITS:0] gain;

  logic [Q_W-1:0]   process_noise;
  logic [R_W-1:0]   measurement_noise;
  logic [LIM_W-1:0] translation_limit;

  logic signed [MOTION_W-1:0] lane_motion [LANES];
  logic signed [MOTION_W-1:0] lane_corr   [LANES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= Q_RESET;
      measurement_noise <= R_RESET;
      translation_limit <= LIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PROCESS_NOISE:     process_noise     <= cfg_data[Q_W-1:0];
        CFG_MEASUREMENT_NOISE: measurement_noise <= cfg_data[R_W-1:0];
        CFG_TRANSLATION_LIMIT: translation_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = in_word.motion_found ? ST_SUM : ST_CORR;
        end
      end
      ST_SUM:  state_next = first_seen ? ST_DIV : ST_CORR;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_CORR;
      ST_CORR: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready         = 1'b0;
    lane_ctrl        = '0;
    cov_ctrl         = '0;
    first_set        = 1'b0;
    out_load         = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SUM: begin
        lane_ctrl.sum_en = 1'b1;
        cov_ctrl.start   = first_seen;
        first_set        = !first_seen;
      end
      ST_DIV: ;
      ST_MUL: begin
        lane_ctrl.mul_en = 1'b1;
        cov_ctrl.mul_en  = 1'b1;
      end
      ST_UPD: begin
        lane_ctrl.est_en = 1'b1;
        cov_ctrl.upd_en  = 1'b1;
      end
      ST_CORR: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      first_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (first_set) begin
        first_seen <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input word holding register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_word;
    end
  end

  // shared gain and covariance
  kms_cov #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cov (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (cov_ctrl),
    .process_noise    (process_noise),
    .measurement_noise(measurement_noise),
    .gain             (gain),
    .div_done         (div_done)
  );

  // trajectory lanes
  assign lane_motion[LANE_TX]    = in_r.trans_x;
  assign lane_motion[LANE_TY]    = in_r.trans_y;
  assign lane_motion[LANE_ANGLE] = in_r.rot_angle;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    kms_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .clamp_en(i != LANE_ANGLE),
      .motion  (lane_motion[i]),
      .gain    (gain),
      .limit   (translation_limit),
      .corr    (lane_corr[i])
    );
  end

  // merge lane results into the output word
  always_comb begin
    out_next = '0;
    if (!in_r.motion_found) begin
      out_next.bypass = 1'b1;
    end else begin
      out_next.corr_trans_x = lane_corr[LANE_TX];
      out_next.corr_trans_y = lane_corr[LANE_TY];
      out_next.corr_angle   = lane_corr[LANE_ANGLE];
      out_next.out_scale_x  = in_r.scale_x;
      out_next.out_scale_y  = in_r.scale_y;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= out_next;
    end
  end

endmodule

// ----- tb/kalman_motion_smoother_unit_tb.sv -----
`timescale 1ns / 100ps

module kalman_motion_smoother_unit_tb;
  import kms_pkg::*;

  // fixed point helpers at the default fraction width
  localparam int FB = FRAC_BITS_DEF;
  localparam longint UNITY = 64'sd1 <<< FB;
  localparam longint HALF_LSB = UNITY >>> 1;
  localparam longint S32_MAX = 64'sh7fff_ffff;
  localparam longint S32_MIN = -64'sh8000_0000;
  localparam longint U32_MAX = 64'sh0000_0000_ffff_ffff;
  localparam logic signed [MOTION_W-1:0] M_MAX = 32'sh7fff_ffff;
  localparam logic signed [MOTION_W-1:0] M_MIN = 32'sh8000_0000;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 197;

  // tracks the trajectory state and holds the smoothed words still due
  class smoothing_scoreboard;
    longint q_noise;
    longint r_noise;
    longint trans_lim;
    int est_tx, est_ty, est_ang;
    int sum_tx, sum_ty, sum_ang;
    longint cov;
    bit seen_motion;
    kms_out_t smoothed_due[$];
    int n_errors, n_checked, n_bypass, n_updates, n_clamped, n_sat;

    function new();
      q_noise = (4 * UNITY + 500) / 1000;
      r_noise = UNITY >>> 1;
      trans_lim = 50 * UNITY;
      cov = UNITY;
      seen_motion = 1'b0;
    endfunction

    // register write, bits above the width dropped, unknown index ignored
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PROCESS_NOISE:     q_noise = longint'(val[Q_W-1:0]);
        CFG_MEASUREMENT_NOISE: r_noise = longint'(val[R_W-1:0]);
        CFG_TRANSLATION_LIMIT: trans_lim = longint'(val[LIM_W-1:0]);
        default: ;
      endcase
    endfunction

    function int sat_word(longint v);
      if (v > S32_MAX) return int'(S32_MAX);
      if (v < S32_MIN) return int'(S32_MIN);
      return int'(v);
    endfunction

    function int add_sat(int acc, int d);
      longint s;
      s = longint'(acc) + longint'(d);
      if (s > S32_MAX || s < S32_MIN) n_sat++;
      return sat_word(s);
    endfunction

    function longint clamp_lim(longint v);
      if (v > trans_lim) return trans_lim;
      if (v < -trans_lim) return -trans_lim;
      return v;
    endfunction

    // one lane of the estimate update, rounded to nearest with ties upward
    function int track(int est, int sum, longint gain);
      longint step;
      step = ((longint'(sum) - longint'(est)) * gain + HALF_LSB) >>> FB;
      return sat_word(longint'(est) + step);
    endfunction

    // accepted frame: advance the trajectory and queue the smoothed word
    function void note_frame(kms_in_t w);
      kms_out_t want;
      int tx, ty, ang;
      longint p1, den, gain, pn, cx, cy;
      want = '0;
      if (!w.motion_found) begin
        want.bypass = 1'b1;
        n_bypass++;
        smoothed_due = {smoothed_due, want};
        return;
      end
      tx = w.trans_x;
      ty = w.trans_y;
      ang = w.rot_angle;
      sum_tx = add_sat(sum_tx, tx);
      sum_ty = add_sat(sum_ty, ty);
      sum_ang = add_sat(sum_ang, ang);
      if (!seen_motion) begin
        seen_motion = 1'b1;
      end else begin
        p1 = cov + q_noise;
        den = p1 + r_noise;
        gain = (den == 0) ? UNITY : (p1 <<< FB) / den;
        if (gain > UNITY) gain = UNITY;
        est_tx = track(est_tx, sum_tx, gain);
        est_ty = track(est_ty, sum_ty, gain);
        est_ang = track(est_ang, sum_ang, gain);
        pn = ((UNITY - gain) * p1 + HALF_LSB) >>> FB;
        cov = (pn > U32_MAX) ? U32_MAX : pn;
        n_updates++;
      end
      cx = longint'(tx) + longint'(est_tx) - longint'(sum_tx);
      cy = longint'(ty) + longint'(est_ty) - longint'(sum_ty);
      if (clamp_lim(cx) != cx || clamp_lim(cy) != cy) n_clamped++;
      want.corr_trans_x = 32'(clamp_lim(cx));
      want.corr_trans_y = 32'(clamp_lim(cy));
      want.corr_angle = sat_word(longint'(ang) + longint'(est_ang) - longint'(sum_ang));
      want.out_scale_x = w.scale_x;
      want.out_scale_y = w.scale_y;
      smoothed_due = {smoothed_due, want};
    endfunction

    function int pending();
      return smoothed_due.size();
    endfunction

    function void compare_field(string name, logic signed [63:0] w, logic signed [63:0] g);
      if (w !== g) begin
        $error("%s mismatch: expected %0d, actual %0d", name, w, g);
        n_errors++;
      end
    endfunction

    // result word against the oldest one due
    function void check_smoothed(kms_out_t got);
      kms_out_t want;
      if (smoothed_due.size() == 0) begin
        $error("result word with no frame waiting: %h", got);
        n_errors++;
        return;
      end
      want = smoothed_due.pop_front();
      n_checked++;
      compare_field("bypass", want.bypass, got.bypass);
      compare_field("corr_trans_x", want.corr_trans_x, got.corr_trans_x);
      compare_field("corr_trans_y", want.corr_trans_y, got.corr_trans_y);
      compare_field("corr_angle", want.corr_angle, got.corr_angle);
      compare_field("out_scale_x", want.out_scale_x, got.out_scale_x);
      compare_field("out_scale_y", want.out_scale_y, got.out_scale_y);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  kms_in_t in_word;
  logic out_valid;
  logic out_ready;
  kms_out_t out_word;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  smoothing_scoreboard mdl;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int n_settings;
  int unsigned phase_in_idle[PHASES] = '{0, 85, 0, 25, 0, 85, 0, 25};
  int unsigned phase_out_stall[PHASES] = '{0, 0, 85, 25, 0, 0, 85, 25};

  kalman_motion_smoother_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: check taken words, then choose next cycle's ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      mdl.check_smoothed(out_word);
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic kms_in_t frame(logic found, logic signed [MOTION_W-1:0] tx,
                                    logic signed [MOTION_W-1:0] ty,
                                    logic signed [MOTION_W-1:0] ang,
                                    logic signed [MOTION_W-1:0] sx,
                                    logic signed [MOTION_W-1:0] sy);
    kms_in_t w;
    w.motion_found = found;
    w.trans_x = tx;
    w.trans_y = ty;
    w.rot_angle = ang;
    w.scale_x = sx;
    w.scale_y = sy;
    return w;
  endfunction

  // mostly a few pixels of motion, some full range, some extremes
  function automatic logic signed [MOTION_W-1:0] pick_motion();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return MOTION_W'(int'($urandom_range(1048575)) - 524288);
    if (sel < 88) return MOTION_W'($urandom());
    case ($urandom_range(4))
      0: return M_MAX;
      1: return M_MIN;
      2: return '0;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  function automatic kms_in_t random_word();
    kms_in_t w;
    w.motion_found = ($urandom_range(99) >= 10);
    w.trans_x = pick_motion();
    w.trans_y = pick_motion();
    w.rot_angle = pick_motion();
    w.scale_x = ($urandom_range(3) == 0) ? MOTION_W'($urandom())
                                          : MOTION_W'($urandom_range(72000, 59000));
    w.scale_y = ($urandom_range(3) == 0) ? MOTION_W'($urandom())
                                          : MOTION_W'($urandom_range(72000, 59000));
    return w;
  endfunction

  // present one word, idling first at random, and wait for it to be taken
  task automatic send_word(input kms_in_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mdl.note_frame(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    mdl.write_reg(idx, val);
  endtask

  // all three registers, with junk above the two noise widths, plus a stray index
  task automatic load_settings(input logic [Q_W-1:0] q, input logic [R_W-1:0] r,
                               input logic [LIM_W-1:0] lim);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    write_reg(CFG_SPARE, junk);
    write_reg(CFG_PROCESS_NOISE, {junk[CFG_DATA_W-1:Q_W], q});
    write_reg(CFG_MEASUREMENT_NOISE, {junk[CFG_DATA_W-1:R_W], r});
    write_reg(CFG_TRANSLATION_LIMIT, lim);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // stop sending and let every due word come back
  task automatic drain();
    in_valid <= 1'b0;
    while (mdl.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // main sequence
  initial begin
    mdl = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    n_settings = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bypass before and after the first motion word, then small steps
    send_word(frame(1'b0, M_MAX, M_MIN, 32'sh1234_5678, M_MIN, M_MAX));
    send_word(frame(1'b1, 32'sd98304, -32'sd131072, 32'sd655, 32'sd65536, M_MAX));
    send_word(frame(1'b0, -1, 1, -1, -1, 1));
    send_word(frame(1'b1, 0, 0, 0, 0, 0));
    send_word(frame(1'b1, 1, -1, 1, 1, -1));
    // full-scale swings: sums saturate, translations clamp, angle saturates
    repeat (4) send_word(frame(1'b1, M_MAX, M_MIN, M_MAX, M_MAX, M_MIN));
    repeat (2) send_word(frame(1'b1, M_MIN, M_MAX, M_MIN, M_MIN, M_MAX));
    send_word(frame(1'b1, M_MAX, M_MIN, M_MAX, M_MAX, M_MIN));
    repeat (3) send_word(frame(1'b1, M_MIN, M_MAX, M_MIN, M_MIN, M_MAX));
    repeat (2) send_word(frame(1'b1, M_MAX, M_MIN, M_MAX, M_MAX, M_MIN));
    send_word(frame(1'b1, M_MIN, M_MAX, M_MIN, M_MIN, M_MAX));
    send_word(frame(1'b1, 32'sd65536, 32'sd65536, -32'sd100, 32'sd65536, 32'sd65536));
    send_word(frame(1'b0, 0, 0, 0, 0, 0));
    drain();

    // no noise at all: covariance collapses and the divisor reaches zero
    load_settings('0, '0, '1);
    repeat (4) send_word(frame(1'b1, 32'sd327680, -32'sd65536, 32'sd1000, 32'sd65536,
                               32'sd65536));
    drain();

    // random phases over register settings and idling mixes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_settings(17'd262, 25'd32768, 31'd3276800);
        1: load_settings('0, 25'd1, '0);
        2: load_settings(17'd65536, 25'd16777216, '1);
        3: load_settings(17'd65536, 25'd1, '1);
        5: load_settings(17'd1, 25'd16777216, 31'd65536);
        6: load_settings(Q_W'($urandom_range(65536)), R_W'($urandom_range(16777216, 1)),
                         LIM_W'($urandom()));
        default: load_settings(Q_W'($urandom_range(1000)), R_W'($urandom_range(262144, 1)),
                               LIM_W'($urandom_range(6553600)));
      endcase
      in_idle_pct = phase_in_idle[ph];
      out_stall_pct = phase_out_stall[ph];
      repeat (WORDS_PER_PHASE) send_word(random_word());
      drain();
    end

    repeat (40) @(posedge clk);
    $display("checked %0d result words: %0d bypass, %0d Kalman updates, %0d clamped",
             mdl.n_checked, mdl.n_bypass, mdl.n_updates, mdl.n_clamped);
    $display("%0d saturated sums over %0d register settings and four idling mixes",
             mdl.n_sat, n_settings);
    if (mdl.n_errors == 0 && mdl.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/kms_pkg.sv
rtl/core/kms_cov.sv
rtl/core/kms_lane.sv
rtl/core/kalman_motion_smoother_unit.sv
tb/kalman_motion_smoother_unit_tb.sv
